>>> src/hsps_pkg.sv
// ----------------------------------------------------------------------------
// H.264 SPS size parser package
// Shared types, state encodings, status codes and the field length table.
// ----------------------------------------------------------------------------
package hsps_pkg;

  typedef enum logic [5:0] {
    PH_HDR, PH_PROF, PH_FLAGS, PH_LEVEL, PH_SPSID, PH_CHROMA, PH_SEP, PH_BDL,
    PH_BDC, PH_BYPASS, PH_SMP, PH_SLP, PH_DELTA, PH_LOG2FN, PH_POCT, PH_LOG2POC,
    PH_DPOAZ, PH_ONRP, PH_OTTB, PH_NREF, PH_OREF, PH_MAXREF, PH_GAPS, PH_WIDTH,
    PH_HEIGHT, PH_FMO, PH_MBAFF, PH_D8, PH_CROPF, PH_CL, PH_CR, PH_CT, PH_CB,
    PH_VUI, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {T_IDLE, T_FEED, T_SIZE, T_LOAD} top_state_t;
  typedef enum logic [1:0] {Z_IDLE, Z_SUM, Z_DIFF} size_state_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_REF   = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_PROF  = 3'd3;
  localparam logic [2:0] ST_SIZE  = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [7:0] PROF_BASE    = 8'd66;
  localparam logic [7:0] PROF_MAIN    = 8'd77;
  localparam logic [7:0] PROF_HIGH    = 8'd100;
  localparam logic [7:0] EPB_BYTE     = 8'h03;

  typedef struct packed {
    logic clear;
    logic start;
    logic high_prof;
    logic bit_valid;
    logic bit_val;
  } bit_cmd_t;

  typedef struct packed {
    logic [31:0] wm1;
    logic [31:0] hm1;
    logic [31:0] cl;
    logic [31:0] cr;
    logic [31:0] ct;
    logic [31:0] cb;
    logic [1:0]  chroma;
    logic        chroma_big;
    logic        sep_plane;
    logic        frame_only;
    logic [7:0]  level;
    logic        done;
  } fields_t;

  typedef struct packed {
    logic        done;
    logic        bad;
    logic [15:0] width;
    logic [15:0] height;
  } size_res_t;

  // Bit length of fixed fields; zero marks an Exp-Golomb field.
  function automatic logic [3:0] fixed_len(phase_t ph);
    logic [3:0] n;
    unique case (ph)
      PH_FLAGS, PH_LEVEL: n = 4'd8;
      PH_SEP, PH_BYPASS, PH_SMP, PH_SLP, PH_DPOAZ, PH_GAPS, PH_FMO, PH_MBAFF,
      PH_D8, PH_CROPF, PH_VUI: n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> src/hsps_bitparse.sv
// ----------------------------------------------------------------------------
// SPS bit parser
// Consumes one payload bit per cycle while cmd.bit_valid is set and walks the SPS syntax fields.
// ----------------------------------------------------------------------------
module hsps_bitparse #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  hsps_pkg::bit_cmd_t cmd,
  output hsps_pkg::fields_t  fields,
  output logic               long_err
);
  import hsps_pkg::*;

  // Captured fields start cleared, except chroma, which defaults to 4:2:0.
  localparam fields_t FIELDS_RESET = '{chroma: 2'd1, default: '0};

  phase_t      phase, phase_next;
  logic [5:0]  pz, pz_next;
  logic [31:0] acc, acc_next;
  logic [5:0]  bl, bl_next;
  logic        insuf, insuf_next;
  logic [3:0]  li, li_next;
  logic [6:0]  coef, coef_next;
  logic [7:0]  last_scale, last_scale_next;
  logic [31:0] cyc, cyc_next;
  fields_t     fr, fr_next;

  logic        tk, beg;
  logic [31:0] v;
  phase_t      nph, lph;
  logic [7:0]  sv, ns;
  logic [6:0]  cn;
  logic [3:0]  ln;
  logic [31:0] cyc_dec;

  always_comb begin
    phase_next = phase; pz_next = pz; acc_next = acc; bl_next = bl;
    insuf_next = insuf; li_next = li; coef_next = coef;
    last_scale_next = last_scale; cyc_next = cyc; fr_next = fr;
    long_err = 1'b0; tk = 1'b0; beg = 1'b0; v = '0; nph = PH_DONE;
    sv = '0; ns = '0; cn = '0; cyc_dec = cyc - 32'd1;
    ln = li + 4'd1;
    lph = (ln < ((fr.chroma == 2'd3 && !fr.chroma_big) ? 4'd12 : 4'd8)) ? PH_SLP : PH_LOG2FN;

    if (cmd.start) begin
      beg = 1'b1;
      nph = PH_FLAGS;
    end else if (cmd.bit_valid && phase >= PH_FLAGS && phase < PH_DONE) begin
      if (fixed_len(phase) != 4'd0) begin
        acc_next = {acc[30:0], cmd.bit_val};
        bl_next  = bl - 6'd1;
        if (bl == 6'd1) begin
          tk = 1'b1;
          v  = acc_next;
        end
      end else if (!insuf) begin
        if (!cmd.bit_val) begin
          pz_next = pz + 6'd1;
          if (pz_next >= 6'(MAX_CODE_BITS)) long_err = 1'b1;
        end else if (pz == 6'd0) begin
          tk = 1'b1;
        end else begin
          insuf_next = 1'b1;
          bl_next    = pz;
          acc_next   = '0;
        end
      end else begin
        acc_next = {acc[30:0], cmd.bit_val};
        bl_next  = bl - 6'd1;
        if (bl == 6'd1) begin
          tk = 1'b1;
          v  = ((32'd1 << pz[4:0]) | acc_next) - 32'd1;
        end
      end
    end

    if (tk) begin
      beg = 1'b1;
      case (phase)
        PH_FLAGS:  nph = PH_LEVEL;
        PH_LEVEL: begin
          fr_next.level = v[7:0];
          nph = PH_SPSID;
        end
        PH_SPSID:  nph = fr.done ? PH_DONE : (cmd.high_prof ? PH_CHROMA : PH_LOG2FN);
        PH_CHROMA: begin
          fr_next.chroma     = v[1:0];
          fr_next.chroma_big = (v[31:2] != '0);
          nph = (v == 32'd3) ? PH_SEP : PH_BDL;
        end
        PH_SEP: begin
          fr_next.sep_plane = v[0];
          nph = PH_BDL;
        end
        PH_BDL:    nph = PH_BDC;
        PH_BDC:    nph = PH_BYPASS;
        PH_BYPASS: nph = PH_SMP;
        PH_SMP: begin
          li_next = '0;
          nph = v[0] ? PH_SLP : PH_LOG2FN;
        end
        PH_SLP: begin
          if (v[0]) begin
            coef_next = '0;
            last_scale_next = 8'd8;
            nph = PH_DELTA;
          end else begin
            li_next = ln;
            nph = lph;
          end
        end
        PH_DELTA: begin
          sv = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
          ns = last_scale + sv;
          if (ns != 8'd0) last_scale_next = ns;
          cn = coef + 7'd1;
          coef_next = cn;
          if (cn >= ((li < 4'd6) ? 7'd16 : 7'd64) || ns == 8'd0) begin
            li_next = ln;
            nph = lph;
          end else begin
            nph = PH_DELTA;
          end
        end
        PH_LOG2FN: nph = PH_POCT;
        PH_POCT: begin
          if (v == 32'd0) nph = PH_LOG2POC;
          else if (v == 32'd1) nph = PH_DPOAZ;
          else nph = PH_MAXREF;
        end
        PH_LOG2POC: nph = PH_MAXREF;
        PH_DPOAZ:   nph = PH_ONRP;
        PH_ONRP:    nph = PH_OTTB;
        PH_OTTB:    nph = PH_NREF;
        PH_NREF: begin
          cyc_next = v;
          nph = (v != 32'd0) ? PH_OREF : PH_MAXREF;
        end
        PH_OREF: begin
          cyc_next = cyc_dec;
          nph = (cyc_dec != 32'd0) ? PH_OREF : PH_MAXREF;
        end
        PH_MAXREF: nph = PH_GAPS;
        PH_GAPS:   nph = PH_WIDTH;
        PH_WIDTH: begin
          fr_next.wm1 = v;
          nph = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          fr_next.hm1 = v;
          nph = PH_FMO;
        end
        PH_FMO: begin
          fr_next.frame_only = v[0];
          nph = v[0] ? PH_D8 : PH_MBAFF;
        end
        PH_MBAFF: nph = PH_D8;
        PH_D8:    nph = PH_CROPF;
        PH_CROPF: nph = v[0] ? PH_CL : PH_VUI;
        PH_CL: begin
          fr_next.cl = v;
          nph = PH_CR;
        end
        PH_CR: begin
          fr_next.cr = v;
          nph = PH_CT;
        end
        PH_CT: begin
          fr_next.ct = v;
          nph = PH_CB;
        end
        PH_CB: begin
          fr_next.cb = v;
          nph = PH_VUI;
        end
        default: nph = PH_DONE;
      endcase
    end

    if (beg) begin
      phase_next = nph;
      bl_next    = {2'b00, fixed_len(nph)};
      pz_next    = '0;
      acc_next   = '0;
      insuf_next = 1'b0;
    end
    fr_next.done = (phase_next == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase <= PH_HDR; pz <= '0; acc <= '0; bl <= '0; insuf <= 1'b0;
      li <= '0; coef <= '0; last_scale <= 8'd8; cyc <= '0;
      fr <= FIELDS_RESET;
    end else begin
      phase <= phase_next; pz <= pz_next; acc <= acc_next; bl <= bl_next;
      insuf <= insuf_next; li <= li_next; coef <= coef_next;
      last_scale <= last_scale_next; cyc <= cyc_next; fr <= fr_next;
    end
  end

  assign fields = fr;

endmodule

>>> src/hsps_size.sv
// ----------------------------------------------------------------------------
// SPS size unit
// Computes cropped width, then height, with one shared add and subtract path.
// ----------------------------------------------------------------------------
module hsps_size (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hsps_pkg::fields_t   fields,
  output hsps_pkg::size_res_t res
);
  import hsps_pkg::*;

  size_state_t state, state_next;
  logic        dim;
  logic [32:0] sum_r;
  logic [36:0] base_r;
  logic        bad, done;
  logic [15:0] width, height;

  logic [32:0] sum_c, m1p;
  logic [1:0]  k;
  logic [34:0] sh;
  logic [37:0] diff;
  logic        ok;

  always_comb begin
    state_next = state;
    unique case (state)
      Z_IDLE:  if (start) state_next = Z_SUM;
      Z_SUM:   state_next = Z_DIFF;
      Z_DIFF:  state_next = dim ? Z_IDLE : Z_SUM;
      default: state_next = Z_IDLE;
    endcase
  end

  always_comb begin
    sum_c = dim ? ({1'b0, fields.ct} + {1'b0, fields.cb})
                : ({1'b0, fields.cl} + {1'b0, fields.cr});
    m1p   = {1'b0, dim ? fields.hm1 : fields.wm1} + 33'd1;
    if (!dim) k = (!fields.sep_plane && (fields.chroma == 2'd1 || fields.chroma == 2'd2))
                  ? 2'd1 : 2'd0;
    else k = (fields.frame_only ? 2'd0 : 2'd1) +
             ((!fields.sep_plane && fields.chroma == 2'd1) ? 2'd1 : 2'd0);
    sh   = {2'b00, sum_r} << k;
    diff = {1'b0, base_r} - {3'b000, sh};
    ok   = (diff[37:16] == '0) && (diff[15:0] != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Z_IDLE;
      dim   <= 1'b0;
      done  <= 1'b0;
      bad   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == Z_DIFF) && dim;
      if (state == Z_IDLE && start) begin
        dim <= 1'b0;
        bad <= 1'b0;
      end else if (state == Z_DIFF) begin
        dim <= ~dim;
        if (!ok) bad <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == Z_SUM) begin
      sum_r  <= sum_c;
      base_r <= {m1p, 4'b0000};
    end
    if (state == Z_DIFF) begin
      if (dim) height <= diff[15:0];
      else width <= diff[15:0];
    end
  end

  assign res = '{done: done, bad: bad, width: width, height: height};

endmodule

>>> src/h264_sps_size_parser_top.sv
// A header byte, profile byte or dropped 0x03 byte is only accepted; a payload byte is
// accepted and then fed to the parser one bit per cycle for its 8 bits.
// After the last byte, the size unit runs sum and difference states for width, then height,
// and the result word loads once the output is free; no byte is taken during a feed.
// Reset is synchronous and active high; after each result all parse state
// returns to its reset value.
// ----------------------------------------------------------------------------
// H.264 SPS size parser top level
// Byte front end with emulation-prevention removal, bit parser, size unit
// and output register.
// ----------------------------------------------------------------------------
module h264_sps_size_parser_top #(
  parameter int MAX_NAL_BYTES = 8192,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], frame_width[18:3], frame_height[34:19], profile_code[42:35],
  // level_code[50:43], chroma_format[52:51], zero pad[55:53]
  output logic [55:0] m_tdata
);
  import hsps_pkg::*;

  localparam int CW = $clog2(MAX_NAL_BYTES + 1);

  top_state_t state, state_next;
  logic [CW-1:0] byte_count;
  logic [1:0]    zero_run, zr_next;
  logic [2:0]    err, err_val;
  logic          err_set;
  logic [7:0]    prof;
  logic [7:0]    shreg;
  logic [2:0]    bitcnt;
  logic          last_pend;

  logic          acc_in, feed_go, start_parse, prof_load, size_start, out_free;
  bit_cmd_t      cmd;
  fields_t       fields;
  logic          long_err;
  size_res_t     size_res;
  logic [2:0]    st;

  assign acc_in   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Byte front end: header checks, profile capture, length limit and 0x03 removal.
  always_comb begin
    feed_go = 1'b0; err_set = 1'b0; err_val = ST_OK;
    start_parse = 1'b0; prof_load = 1'b0; zr_next = zero_run;
    if (acc_in && err == ST_OK) begin
      if (byte_count == '0) begin
        if (s_tdata[6:5] == 2'd0) begin
          err_set = 1'b1; err_val = ST_REF;
        end else if (s_tdata[4:0] != NAL_TYPE_SPS) begin
          err_set = 1'b1; err_val = ST_TYPE;
        end
      end else if (byte_count == CW'(1)) begin
        prof_load = 1'b1;
        if (s_tdata != PROF_BASE && s_tdata != PROF_MAIN && s_tdata != PROF_HIGH) begin
          err_set = 1'b1; err_val = ST_PROF;
        end else begin
          start_parse = 1'b1;
        end
      end else if (byte_count >= CW'(MAX_NAL_BYTES)) begin
        err_set = 1'b1; err_val = ST_TRUNC;
      end else if (zero_run == 2'd2 && s_tdata == EPB_BYTE) begin
        zr_next = 2'd0;
      end else begin
        zr_next = (s_tdata == 8'd0) ? ((zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1) : 2'd0;
        feed_go = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (acc_in) begin
          if (feed_go) state_next = T_FEED;
          else if (s_tlast) state_next = T_SIZE;
        end
      end
      T_FEED:  if (bitcnt == 3'd7) state_next = last_pend ? T_SIZE : T_IDLE;
      T_SIZE:  if (size_res.done) state_next = T_LOAD;
      T_LOAD:  if (out_free) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    s_tready      = (state == T_IDLE);
    size_start    = (state == T_IDLE && acc_in && !feed_go && s_tlast) ||
                    (state == T_FEED && bitcnt == 3'd7 && last_pend);
    cmd.clear     = (state == T_LOAD) && out_free;
    cmd.start     = start_parse;
    cmd.high_prof = (prof == PROF_HIGH);
    cmd.bit_valid = (state == T_FEED) && (err == ST_OK);
    cmd.bit_val   = shreg[7];
  end

  // The profile flag for the chroma branch comes from the stored profile byte.
  hsps_bitparse #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_bits (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .fields   (fields),
    .long_err (long_err)
  );

  hsps_size u_size (
    .clk    (clk),
    .rst    (rst),
    .start  (size_start),
    .fields (fields),
    .res    (size_res)
  );

  // Final status: first error wins, then a unit that ended early, then size checks.
  always_comb begin
    if (err != ST_OK) st = err;
    else if (!fields.done) st = ST_TRUNC;
    else if (fields.chroma_big || size_res.bad) st = ST_SIZE;
    else st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      byte_count <= '0;
      zero_run <= '0;
      err <= ST_OK;
      prof <= '0;
      bitcnt <= '0;
      last_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.clear) begin
        byte_count <= '0;
        zero_run <= '0;
        err <= ST_OK;
        prof <= '0;
        last_pend <= 1'b0;
      end else begin
        if (acc_in) begin
          if (byte_count < CW'(MAX_NAL_BYTES)) byte_count <= byte_count + CW'(1);
          zero_run <= zr_next;
          last_pend <= s_tlast;
          if (prof_load) prof <= s_tdata;
        end
        if (err_set) err <= err_val;
        else if (long_err && err == ST_OK) err <= ST_TRUNC;
      end
      if (state == T_FEED) bitcnt <= bitcnt + 3'd1;
      else bitcnt <= '0;
      if (state == T_LOAD && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) shreg <= s_tdata;
    else if (state == T_FEED) shreg <= {shreg[6:0], 1'b0};
    if (state == T_LOAD && out_free) begin
      m_tdata <= {3'b000,
                  fields.chroma_big ? 2'd3 : fields.chroma,
                  fields.level,
                  prof,
                  (st == ST_OK) ? size_res.height : 16'd0,
                  (st == ST_OK) ? size_res.width : 16'd0,
                  st};
    end
  end

  // The status code never leaves its defined range.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ST_TRUNC))
    else $error("status code out of range");

  // A failed unit reports a zero size.
  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != ST_OK) |-> (m_tdata[34:3] == '0))
    else $error("nonzero size with error status");

  // The size unit finishes only while the sequencer waits for it.
  a_size_done: assert property (@(posedge clk) disable iff (rst)
    size_res.done |-> (state == T_SIZE))
    else $error("size unit finished outside its wait state");

  // No input word is taken while a byte is being shifted into the parser.
  a_feed_busy: assert property (@(posedge clk) disable iff (rst)
    (state == T_FEED) |-> !s_tready)
    else $error("input accepted during bit feed");

endmodule
